/* src/rgb_led_pattern_generator_top_macros.svh */
// Assertion macros shared by the LED pattern generator modules.
`ifndef RGB_LED_PATTERN_GENERATOR_TOP_MACROS_SVH
`define RGB_LED_PATTERN_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RLPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlpg assertion failed");

// Next-cycle implication, checked out of reset.
`define RLPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlpg assertion failed");

`endif

/* src/rlpg_pkg.sv */
// Shared constants, types and tables of the LED pattern generator.
package rlpg_pkg;

    localparam int CHAIN_MAX  = 16;
    localparam int LED_IDX_W  = 4;
    localparam int CNT_W      = 5;
    localparam int HUE_W      = 13;
    localparam int WGT_W      = 17;
    localparam int HUE_FULL   = 5760;
    localparam int HUE_SECTOR = 960;

    // pattern codes
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_SOLID   = 3'd1;
    localparam logic [2:0] MODE_SLOW    = 3'd2;
    localparam logic [2:0] MODE_FAST    = 3'd3;
    localparam logic [2:0] MODE_BREATHE = 3'd4;
    localparam logic [2:0] MODE_RAINBOW = 3'd5;

    // register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_COLOR  = 2'd1;
    localparam logic [1:0] REG_BRIGHT = 2'd2;
    localparam logic [1:0] REG_COUNT  = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] color;
        logic [7:0]  bright;
    } t_cfg;

    // per time stamp results of the time unit
    typedef struct packed {
        logic             slow_off;
        logic             fast_off;
        logic [WGT_W-1:0] weight;
        logic [HUE_W-1:0] hue;
    } t_time_info;

    // one LED of a frame
    typedef struct packed {
        logic [LED_IDX_W-1:0] idx;
        logic                 last;
        logic [HUE_W-1:0]     offset;
        t_time_info           ti;
    } t_led_tok;

    typedef struct packed {
        logic [HUE_W-1:0] q;
        logic [CNT_W-1:0] r;
    } t_step;

    // floor(x / 255), exact for x <= 65025
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] tmp;
        tmp = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return tmp[15:8];
    endfunction

    // hue step between neighbouring LEDs: 5760 = q*n + r
    function automatic t_step led_step(input logic [CNT_W-1:0] n);
        t_step s;
        unique case (n)
            5'd1:    s = '{q: 13'd5760, r: 5'd0};
            5'd2:    s = '{q: 13'd2880, r: 5'd0};
            5'd3:    s = '{q: 13'd1920, r: 5'd0};
            5'd4:    s = '{q: 13'd1440, r: 5'd0};
            5'd5:    s = '{q: 13'd1152, r: 5'd0};
            5'd6:    s = '{q: 13'd960,  r: 5'd0};
            5'd7:    s = '{q: 13'd822,  r: 5'd6};
            5'd8:    s = '{q: 13'd720,  r: 5'd0};
            5'd9:    s = '{q: 13'd640,  r: 5'd0};
            5'd10:   s = '{q: 13'd576,  r: 5'd0};
            5'd11:   s = '{q: 13'd523,  r: 5'd7};
            5'd12:   s = '{q: 13'd480,  r: 5'd0};
            5'd13:   s = '{q: 13'd443,  r: 5'd1};
            5'd14:   s = '{q: 13'd411,  r: 5'd6};
            5'd15:   s = '{q: 13'd384,  r: 5'd0};
            5'd16:   s = '{q: 13'd360,  r: 5'd0};
            default: s = '{q: 13'd5760, r: 5'd0};
        endcase
        return s;
    endfunction

    // quarter-wave cosine, Q1.16
    function automatic logic [16:0] cos_q16(input logic [6:0] k);
        logic [16:0] c;
        case (k)
            7'd0:  c = 17'd65536; 7'd1:  c = 17'd65516; 7'd2:  c = 17'd65457;
            7'd3:  c = 17'd65358; 7'd4:  c = 17'd65220; 7'd5:  c = 17'd65043;
            7'd6:  c = 17'd64827; 7'd7:  c = 17'd64571; 7'd8:  c = 17'd64277;
            7'd9:  c = 17'd63944; 7'd10: c = 17'd63572; 7'd11: c = 17'd63162;
            7'd12: c = 17'd62714; 7'd13: c = 17'd62228; 7'd14: c = 17'd61705;
            7'd15: c = 17'd61145; 7'd16: c = 17'd60547; 7'd17: c = 17'd59914;
            7'd18: c = 17'd59244; 7'd19: c = 17'd58538; 7'd20: c = 17'd57798;
            7'd21: c = 17'd57022; 7'd22: c = 17'd56212; 7'd23: c = 17'd55368;
            7'd24: c = 17'd54491; 7'd25: c = 17'd53581; 7'd26: c = 17'd52639;
            7'd27: c = 17'd51665; 7'd28: c = 17'd50660; 7'd29: c = 17'd49624;
            7'd30: c = 17'd48559; 7'd31: c = 17'd47464; 7'd32: c = 17'd46341;
            7'd33: c = 17'd45190; 7'd34: c = 17'd44011; 7'd35: c = 17'd42806;
            7'd36: c = 17'd41576; 7'd37: c = 17'd40320; 7'd38: c = 17'd39040;
            7'd39: c = 17'd37736; 7'd40: c = 17'd36410; 7'd41: c = 17'd35062;
            7'd42: c = 17'd33692; 7'd43: c = 17'd32303; 7'd44: c = 17'd30893;
            7'd45: c = 17'd29466; 7'd46: c = 17'd28020; 7'd47: c = 17'd26558;
            7'd48: c = 17'd25080; 7'd49: c = 17'd23586; 7'd50: c = 17'd22078;
            7'd51: c = 17'd20557; 7'd52: c = 17'd19024; 7'd53: c = 17'd17479;
            7'd54: c = 17'd15924; 7'd55: c = 17'd14359; 7'd56: c = 17'd12785;
            7'd57: c = 17'd11204; 7'd58: c = 17'd9616;  7'd59: c = 17'd8022;
            7'd60: c = 17'd6424;  7'd61: c = 17'd4821;  7'd62: c = 17'd3216;
            7'd63: c = 17'd1608;
            default: c = 17'd0;
        endcase
        return c;
    endfunction

endpackage

/* src/rlpg_time_unit.sv */
// Six-stage pipeline turning a time stamp into blink flags, breathe weight and base hue.
`include "rgb_led_pattern_generator_top_macros.svh"

module rlpg_time_unit
    import rlpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_time_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_time_info  o_info
);

    localparam int NST = 6;

    typedef struct packed {
        logic [21:0]      x;
        logic [8:0]       qe;
        logic [13:0]      r10;
        logic [10:0]      p2000;
        logic [12:0]      p5000;
        logic             slow_off;
        logic             fast_off;
        logic [7:0]       j;
        logic [HUE_W-1:0] hue;
        logic [WGT_W-1:0] weight;
    } t_tu_st;

    logic   [NST-1:0] r_v;
    logic   [NST-1:0] rdy;
    t_tu_st           r_st [NST];
    t_tu_st           n_st [NST];

    always_comb begin
        rdy[NST-1] = !r_v[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    // stage 0: t mod 10000 folded to a 22-bit sum of byte residues
    always_comb begin
        n_st[0]   = r_st[0];
        n_st[0].x = {14'd0, i_time_ms[7:0]}
                  + {6'd0, i_time_ms[15:8], 8'd0}
                  + ({14'd0, i_time_ms[23:16]} * 22'd5536)
                  + ({14'd0, i_time_ms[31:24]} * 22'd7216);
    end

    // stage 1: quotient estimate, low by at most one
    always_comb begin
        logic [34:0] p;
        p          = {13'd0, r_st[0].x} * 35'd6710;
        n_st[1]    = r_st[0];
        n_st[1].qe = p[34:26];
    end

    // stage 2: remainder with one correction
    always_comb begin
        logic [21:0] m;
        logic [21:0] r;
        m = {13'd0, r_st[1].qe} * 22'd10000;
        r = r_st[1].x - m;
        n_st[2] = r_st[1];
        if (r >= 22'd10000) begin
            r = r - 22'd10000;
        end
        n_st[2].r10 = r[13:0];
    end

    // stage 3: residues of the breathe and rainbow periods
    always_comb begin
        logic [13:0] r;
        r       = r_st[2].r10;
        n_st[3] = r_st[2];
        if (r >= 14'd8000) begin
            n_st[3].p2000 = 11'(r - 14'd8000);
        end else if (r >= 14'd6000) begin
            n_st[3].p2000 = 11'(r - 14'd6000);
        end else if (r >= 14'd4000) begin
            n_st[3].p2000 = 11'(r - 14'd4000);
        end else if (r >= 14'd2000) begin
            n_st[3].p2000 = 11'(r - 14'd2000);
        end else begin
            n_st[3].p2000 = r[10:0];
        end
        n_st[3].p5000 = (r >= 14'd5000) ? 13'(r - 14'd5000) : r[12:0];
    end

    // stage 4: blink flags, phase index and base hue
    always_comb begin
        logic [10:0] p1000;
        logic        par;
        logic [26:0] pj;
        logic [34:0] ph;
        p1000 = (r_st[3].p2000 >= 11'd1000) ? (r_st[3].p2000 - 11'd1000) : r_st[3].p2000;
        par   = 1'b0;
        for (int k = 1; k <= 9; k++) begin
            par = par ^ (p1000 >= 11'(k * 100));
        end
        pj = {16'd0, r_st[3].p2000} * 27'd33555;
        ph = {22'd0, r_st[3].p5000} * 35'd2550142;
        n_st[4]          = r_st[3];
        n_st[4].slow_off = (p1000 >= 11'd500);
        n_st[4].fast_off = par;
        n_st[4].j        = pj[25:18];
        n_st[4].hue      = r_st[3].p5000 + {3'd0, ph[33:24]};
    end

    // stage 5: raised-cosine weight
    always_comb begin
        logic [7:0]  j;
        logic [6:0]  k;
        logic        neg;
        logic [16:0] c;
        logic [17:0] w;
        j = r_st[4].j;
        if (j <= 8'd64) begin
            k   = j[6:0];
            neg = 1'b0;
        end else if (j <= 8'd128) begin
            k   = 7'(8'd128 - j);
            neg = 1'b1;
        end else if (j <= 8'd192) begin
            k   = 7'(j - 8'd128);
            neg = 1'b1;
        end else begin
            k   = 7'(9'd256 - {1'b0, j});
            neg = 1'b0;
        end
        c = cos_q16(k);
        w = neg ? (18'd65536 + {1'b0, c}) : (18'd65536 - {1'b0, c});
        n_st[5]        = r_st[4];
        n_st[5].weight = w[17:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_in_ready       = rdy[0];
    assign o_out_valid      = r_v[NST-1];
    assign o_info.slow_off  = r_st[NST-1].slow_off;
    assign o_info.fast_off  = r_st[NST-1].fast_off;
    assign o_info.weight    = r_st[NST-1].weight;
    assign o_info.hue       = r_st[NST-1].hue;

    `RLPG_ASSERT_IMPL(a_rem_range, i_clk, i_rst_n, r_v[2], r_st[2].r10 < 14'd10000)
    `RLPG_ASSERT_IMPL(a_out_range, i_clk, i_rst_n, r_v[NST-1],
        (r_st[NST-1].weight <= 17'd65536) && (r_st[NST-1].hue < 13'(HUE_FULL)))

endmodule

/* src/rlpg_led_sequencer.sv */
// Expands one time item into one token per LED of the chain.
`include "rgb_led_pattern_generator_top_macros.svh"

module rlpg_led_sequencer
    import rlpg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_led_count,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_time_info       i_info,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_led_tok         o_tok
);

    logic                 r_valid;
    t_time_info           r_info;
    logic [LED_IDX_W-1:0] r_idx;
    logic [CNT_W-1:0]     r_n;
    logic [HUE_W-1:0]     r_off;
    logic [CNT_W-1:0]     r_rem;

    logic             last;
    logic             take;
    logic [CNT_W-1:0] n_cnt;
    t_step            step;
    logic [CNT_W:0]   rem_sum;

    always_comb begin
        if (i_led_count == '0) begin
            n_cnt = CNT_W'(1);
        end else if (i_led_count > CNT_W'(CHAIN_MAX)) begin
            n_cnt = CNT_W'(CHAIN_MAX);
        end else begin
            n_cnt = i_led_count;
        end
    end

    assign last    = ({1'b0, r_idx} == (r_n - CNT_W'(1)));
    assign take    = !r_valid || (i_out_ready && last);
    assign step    = led_step(r_n);
    assign rem_sum = {1'b0, r_rem} + {1'b0, step.r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_in_valid;
        end
    end

    // offset = floor(idx * 5760 / n), kept as quotient plus remainder
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_info <= i_info;
            r_n    <= n_cnt;
            r_idx  <= '0;
            r_off  <= '0;
            r_rem  <= '0;
        end else if (i_out_ready) begin
            r_idx <= r_idx + LED_IDX_W'(1);
            if (rem_sum >= {1'b0, r_n}) begin
                r_rem <= CNT_W'(rem_sum - {1'b0, r_n});
                r_off <= r_off + step.q + HUE_W'(1);
            end else begin
                r_rem <= rem_sum[CNT_W-1:0];
                r_off <= r_off + step.q;
            end
        end
    end

    assign o_in_ready   = take;
    assign o_out_valid  = r_valid;
    assign o_tok.idx    = r_idx;
    assign o_tok.last   = last;
    assign o_tok.offset = r_off;
    assign o_tok.ti     = r_info;

    `RLPG_ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, r_valid,
        ({1'b0, r_idx} < r_n) && (r_rem < r_n))
    `RLPG_ASSERT_IMPL(a_off_range, i_clk, i_rst_n, r_valid, r_off < 13'(HUE_FULL))
    `RLPG_ASSERT_NEXT(a_frame_holds, i_clk, i_rst_n, r_valid && i_out_ready && !last,
        r_valid && (r_idx != '0))

endmodule

/* src/rlpg_led_pipe.sv */
// Five-stage per-LED colour pipeline: scaling, hue sector, breathe and rainbow ramp.
`include "rgb_led_pattern_generator_top_macros.svh"

module rlpg_led_pipe
    import rlpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_led_tok             i_tok,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [LED_IDX_W-1:0] o_led_index,
    output logic [7:0]           o_red_level,
    output logic [7:0]           o_green_level,
    output logic [7:0]           o_blue_level,
    output logic                 o_last_led
);

    localparam int NST = 5;

    // channel 2 red, 1 green, 0 blue
    typedef struct packed {
        logic [LED_IDX_W-1:0] idx;
        logic                 last;
        logic                 slow_off;
        logic                 fast_off;
        logic [WGT_W-1:0]     weight;
        logic [HUE_W-1:0]     h;
        logic [2:0][7:0]      s;
        logic [2:0][7:0]      bw;
        logic [2:0]           sec;
        logic [9:0]           q;
        logic [11:0]          y;
        logic [7:0]           x;
        logic [2:0][7:0]      rgb;
    } t_px;

    logic [NST-1:0] r_v;
    logic [NST-1:0] rdy;
    t_px            r_st [NST];
    t_px            n_st [NST];

    always_comb begin
        rdy[NST-1] = !r_v[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    // stage 0: LED hue and brightness-scaled colour
    always_comb begin
        logic [HUE_W:0] hs;
        logic [15:0]    p;
        hs = {1'b0, i_tok.ti.hue} + {1'b0, i_tok.offset};
        if (hs >= (HUE_W+1)'(HUE_FULL)) begin
            hs = hs - (HUE_W+1)'(HUE_FULL);
        end
        n_st[0]          = r_st[0];
        n_st[0].idx      = i_tok.idx;
        n_st[0].last     = i_tok.last;
        n_st[0].slow_off = i_tok.ti.slow_off;
        n_st[0].fast_off = i_tok.ti.fast_off;
        n_st[0].weight   = i_tok.ti.weight;
        n_st[0].h        = hs[HUE_W-1:0];
        for (int c = 0; c < 3; c++) begin
            p = {8'd0, i_cfg.color[c*8 +: 8]} * {8'd0, i_cfg.bright};
            n_st[0].s[c] = div255(p);
        end
    end

    // stage 1: sector and ramp position, breathe products
    always_comb begin
        logic [HUE_W-1:0] base;
        logic [HUE_W-1:0] f;
        logic [24:0]      pb;
        n_st[1]     = r_st[0];
        n_st[1].sec = 3'd0;
        base        = '0;
        for (int k = 1; k <= 5; k++) begin
            if (r_st[0].h >= HUE_W'(k * HUE_SECTOR)) begin
                n_st[1].sec = 3'(k);
                base        = HUE_W'(k * HUE_SECTOR);
            end
        end
        f = r_st[0].h - base;
        n_st[1].q = n_st[1].sec[0] ? 10'(HUE_W'(HUE_SECTOR) - f) : f[9:0];
        for (int c = 0; c < 3; c++) begin
            pb = {17'd0, r_st[0].s[c]} * {8'd0, r_st[0].weight};
            n_st[1].bw[c] = pb[23:16];
        end
    end

    // stage 2: ramp times brightness, pre-divided by 64
    always_comb begin
        logic [17:0] z;
        z         = {8'd0, r_st[1].q} * {10'd0, i_cfg.bright};
        n_st[2]   = r_st[1];
        n_st[2].y = z[17:6];
    end

    // stage 3: divide by 15 through the reciprocal
    always_comb begin
        logic [24:0] px;
        px        = {13'd0, r_st[2].y} * 25'd4370;
        n_st[3]   = r_st[2];
        n_st[3].x = px[23:16];
    end

    // stage 4: pattern select
    always_comb begin
        logic [7:0] br;
        logic [7:0] x;
        br          = i_cfg.bright;
        x           = r_st[3].x;
        n_st[4]     = r_st[3];
        n_st[4].rgb = '0;
        case (i_cfg.mode)
            MODE_SOLID:   n_st[4].rgb = r_st[3].s;
            MODE_SLOW:    n_st[4].rgb = r_st[3].slow_off ? '0 : r_st[3].s;
            MODE_FAST:    n_st[4].rgb = r_st[3].fast_off ? '0 : r_st[3].s;
            MODE_BREATHE: n_st[4].rgb = r_st[3].bw;
            MODE_RAINBOW: begin
                case (r_st[3].sec)
                    3'd0:    n_st[4].rgb = {br, x, 8'd0};
                    3'd1:    n_st[4].rgb = {x, br, 8'd0};
                    3'd2:    n_st[4].rgb = {8'd0, br, x};
                    3'd3:    n_st[4].rgb = {8'd0, x, br};
                    3'd4:    n_st[4].rgb = {x, 8'd0, br};
                    default: n_st[4].rgb = {br, 8'd0, x};
                endcase
            end
            default:      n_st[4].rgb = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_in_ready    = rdy[0];
    assign o_out_valid   = r_v[NST-1];
    assign o_led_index   = r_st[NST-1].idx;
    assign o_red_level   = r_st[NST-1].rgb[2];
    assign o_green_level = r_st[NST-1].rgb[1];
    assign o_blue_level  = r_st[NST-1].rgb[0];
    assign o_last_led    = r_st[NST-1].last;

    `RLPG_ASSERT_IMPL(a_hue_range, i_clk, i_rst_n, r_v[0], r_st[0].h < 13'(HUE_FULL))
    `RLPG_ASSERT_IMPL(a_ramp_range, i_clk, i_rst_n, r_v[1],
        (r_st[1].sec <= 3'd5) && (r_st[1].q <= 10'(HUE_SECTOR)))

endmodule

/* src/rgb_led_pattern_generator_top.sv */
// Top level of the RGB LED pattern generator: register file and pipeline hookup.
//
// Input channel (i_in_valid / o_in_ready): one item is a time stamp i_time_ms.
// Output channel (o_out_valid / i_out_ready): one item per LED in use, in
// chain order, carrying o_led_index, the three levels and o_last_led, which
// marks the final LED of the frame.
// Configuration is written over the APB port (pattern_mode at 0x0, base_color
// at 0x4, brightness_level at 0x8, led_count at 0xC); pready is tied high.
// Path: a time stamp passes 6 time stages, 1 sequencer stage and 5 colour
// stages before the first result of its frame leaves.
// Throughput: one result per cycle while i_out_ready is high; the sequencer
// holds a frame of n LEDs until its n tokens are sent and takes no new time
// stamp meanwhile, while the time pipeline buffers up to six more.
// Reset clears all valid bits and loads pattern_mode 0, base_color 0,
// brightness_level 255 and led_count 1.
// A stall holds full stages up to a bubble; no item is dropped or repeated.
module rgb_led_pattern_generator_top
    import rlpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_time_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_led_index,
    output logic [7:0]  o_red_level,
    output logic [7:0]  o_green_level,
    output logic [7:0]  o_blue_level,
    output logic        o_last_led
);

    logic [2:0]       r_mode;
    logic [23:0]      r_color;
    logic [7:0]       r_bright;
    logic [CNT_W-1:0] r_count;

    t_cfg       cfg;
    logic       tu_valid;
    logic       tu_ready;
    t_time_info tu_info;
    logic       sq_valid;
    logic       sq_ready;
    t_led_tok   sq_tok;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_color  <= '0;
            r_bright <= 8'd255;
            r_count  <= CNT_W'(1);
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_MODE:   r_mode   <= pwdata[2:0];
                REG_COLOR:  r_color  <= pwdata[23:0];
                REG_BRIGHT: r_bright <= pwdata[7:0];
                REG_COUNT:  r_count  <= pwdata[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:   prdata = {29'd0, r_mode};
            REG_COLOR:  prdata = {8'd0, r_color};
            REG_BRIGHT: prdata = {24'd0, r_bright};
            REG_COUNT:  prdata = {{(32-CNT_W){1'b0}}, r_count};
            default:    prdata = '0;
        endcase
    end

    assign cfg.mode   = r_mode;
    assign cfg.color  = r_color;
    assign cfg.bright = r_bright;

    rlpg_time_unit u_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_time_ms   (i_time_ms),
        .o_out_valid (tu_valid),
        .i_out_ready (tu_ready),
        .o_info      (tu_info)
    );

    rlpg_led_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_led_count (r_count),
        .i_in_valid  (tu_valid),
        .o_in_ready  (tu_ready),
        .i_info      (tu_info),
        .o_out_valid (sq_valid),
        .i_out_ready (sq_ready),
        .o_tok       (sq_tok)
    );

    rlpg_led_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (sq_valid),
        .o_in_ready    (sq_ready),
        .i_tok         (sq_tok),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_led_index   (o_led_index),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_last_led    (o_last_led)
    );

endmodule
